FILE: rtl/dq_pkg.sv
// Shared constants and types for the double-ended queue.
// Used by dq_ring_ram and double_ended_queue; depends on nothing.
package dq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
   } ram_req_type;

endpackage

FILE: rtl/dq_ring_ram.sv
// Ring storage: one write and one read port, registered read data.
// Depends on dq_pkg for sizes and the request struct.
module dq_ring_ram (
   input  logic                           clock,
   input  dq_pkg::ram_req_type            ram_req,
   output logic [dq_pkg::DATA_WIDTH-1:0]  rd_data
);

   logic [dq_pkg::DATA_WIDTH-1:0] mem [dq_pkg::DEPTH];
   logic [dq_pkg::DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/double_ended_queue.sv
// Double-ended queue over a ring memory with head pointer and entry count.
// Depends on dq_pkg and dq_ring_ram.
//
//   channel  direction  beat fields                       handshake
//   req      in         kind, value                       req_valid / req_stall
//   rsp      out        status, data, occupancy           rsp_valid / rsp_stall
//
// For each request, pointer and count update at acceptance, a read
// is issued to the ring memory in that cycle and its data appears with the beat
// on the next cycle. One request per cycle is sustained while rsp is not stalled.
// Synchronous active-high reset empties the queue; the memory is not cleared.
// A held rsp beat stalls req until it is taken.
module double_ended_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dq_pkg::KIND_W-1:0]     req_kind,
   input  logic [dq_pkg::VALUE_W-1:0]    req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dq_pkg::STAT_W-1:0]     rsp_status,
   output logic [dq_pkg::VALUE_W-1:0]    rsp_data,
   output logic [dq_pkg::OCC_W-1:0]      rsp_occupancy
);

   logic [dq_pkg::ADDR_W-1:0]     head_ff, head_in;
   logic [dq_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dq_pkg::STAT_W-1:0]     status_ff, status_in;
   logic [dq_pkg::CNT_W-1:0]      occ_ff;
   logic                          rdsel_ff, rdsel_in;

   logic                          accept;
   logic                          full, empty;
   logic [dq_pkg::ADDR_W-1:0]     head_dec, head_inc, tail_idx, rear_idx;
   logic [dq_pkg::SUM_W-1:0]      sum, sum_m1;
   dq_pkg::ram_req_type           ram_req;
   logic [dq_pkg::DATA_WIDTH-1:0] rd_data;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      head_dec = (head_ff == '0) ? dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1) : head_ff - 1'b1;
      head_inc = (head_ff == dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1)) ? '0 : head_ff + 1'b1;
      sum      = dq_pkg::SUM_W'(head_ff) + dq_pkg::SUM_W'(count_ff);
      sum_m1   = sum - 1'b1;
      tail_idx = (sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                 ? dq_pkg::ADDR_W'(sum - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                 : dq_pkg::ADDR_W'(sum);
      rear_idx = (sum_m1 >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                 ? dq_pkg::ADDR_W'(sum_m1 - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                 : dq_pkg::ADDR_W'(sum_m1);
   end

   always_comb begin
      head_in         = head_ff;
      count_in        = count_ff;
      status_in       = dq_pkg::ST_OK;
      rdsel_in        = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = tail_idx;
      ram_req.wr_data = dq_pkg::DATA_WIDTH'(req_value);
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = head_ff;
      case (req_kind)
         dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_REAR: begin
            if (full) begin
               status_in = dq_pkg::ST_FULL;
            end else begin
               ram_req.wr_en = accept;
               count_in      = count_ff + 1'b1;
               if (req_kind == dq_pkg::KIND_PUSH_FRONT) begin
                  ram_req.wr_addr = head_dec;
                  head_in         = head_dec;
               end
            end
         end
         dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_PEEK_FRONT: begin
            if (empty) begin
               status_in = dq_pkg::ST_EMPTY;
            end else begin
               ram_req.rd_en = accept;
               rdsel_in      = 1'b1;
               if (req_kind == dq_pkg::KIND_POP_FRONT) begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::KIND_POP_REAR, dq_pkg::KIND_PEEK_REAR: begin
            ram_req.rd_addr = rear_idx;
            if (empty) begin
               status_in = dq_pkg::ST_EMPTY;
            end else begin
               ram_req.rd_en = accept;
               rdsel_in      = 1'b1;
               if (req_kind == dq_pkg::KIND_POP_REAR) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::KIND_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         occ_ff    <= count_in;
         rdsel_ff  <= rdsel_in;
      end
   end

   dq_ring_ram u_ring_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_data      = rdsel_ff ? dq_pkg::VALUE_W'(rd_data) : '0;
   assign rsp_occupancy = dq_pkg::OCC_W'(occ_ff);

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
      else $error("entry count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1))
      else $error("head pointer out of range");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      accept && full && (req_kind == dq_pkg::KIND_PUSH_FRONT ||
                         req_kind == dq_pkg::KIND_PUSH_REAR)
      |=> $stable(count_ff) && $stable(head_ff))
      else $error("push into full queue changed state");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      accept && !empty && (req_kind == dq_pkg::KIND_POP_FRONT ||
                           req_kind == dq_pkg::KIND_POP_REAR)
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not drop one entry");

   a_data_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dq_pkg::ST_OK |-> rsp_data == '0)
      else $error("data not zero on non-ok beat");
`endif

endmodule
